FILE: design/mqtb_pkg.sv
package mqtb_pkg;

  // Fixed field widths
  localparam int TaskW   = 6;
  localparam int NumIds  = 64;
  localparam int CmdW    = 2;
  localparam int CpuW    = 3;
  localparam int StatusW = 3;
  localparam int UsedW   = 3;
  localparam int FillW   = 7;
  localparam int CfgW    = 4;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_BAL   = 2'd0,
    CMD_LOCAL = 2'd1,
    CMD_DISP  = 2'd2,
    CMD_NONE  = 2'd3
  } mqtb_cmd_t;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_ENQ    = 3'd0,
    ST_DISP   = 3'd1,
    ST_STOLEN = 3'd2,
    ST_IDLE   = 3'd3,
    ST_DUP    = 3'd4,
    ST_NOTGT  = 3'd5,
    ST_BADCPU = 3'd6
  } mqtb_status_t;

  // Control of the shared size comparator
  typedef struct packed {
    logic clear;
    logic step;
    logic find_max;
    logic skip;
  } mqtb_scan_ctl_t;

  // Write enables of the slot and membership memories
  typedef struct packed {
    logic slot_we;
    logic memb_we;
  } mqtb_mem_ctl_t;

endpackage

FILE: design/mqtb_scan.sv
module mqtb_scan import mqtb_pkg::*; #(
  parameter int MAX_CPUS  = 8,
  parameter int PID_COUNT = 64,
  localparam int QW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1,
  localparam int CW = $clog2(PID_COUNT + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mqtb_scan_ctl_t ctl,
  input  logic [QW-1:0]  idx,
  input  logic [CW-1:0]  size,
  output logic           found,
  output logic [QW-1:0]  sel
);

  localparam logic [CW-1:0] FullCnt = CW'(PID_COUNT);

  logic          found_r;
  logic [QW-1:0] sel_r;
  logic [CW-1:0] ext_r;
  logic          hit;

  // Compare one queue size against the running extreme
  always_comb begin
    if (ctl.find_max) begin
      hit = !ctl.skip && (size > ext_r);
    end else begin
      hit = (size < FullCnt) && (!found_r || (size < ext_r));
    end
  end

  // Track whether any queue qualified
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (ctl.step && hit) begin
      found_r <= 1'b1;
    end
  end

  // Hold the first queue of extreme size and that size
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sel_r <= '0;
      ext_r <= '0;
    end else if (ctl.step && hit) begin
      sel_r <= idx;
      ext_r <= size;
    end
  end

  assign found = found_r;
  assign sel   = sel_r;

endmodule

FILE: design/mqtb_qregs.sv
module mqtb_qregs import mqtb_pkg::*; #(
  parameter int MAX_CPUS  = 8,
  parameter int PID_COUNT = 64,
  localparam int QW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1,
  localparam int PW = $clog2(PID_COUNT),
  localparam int CW = $clog2(PID_COUNT + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [QW-1:0] q,
  input  logic [PW-1:0] head_wr,
  input  logic [CW-1:0] count_wr,
  output logic [PW-1:0] head_rd,
  output logic [CW-1:0] count_rd
);

  logic [PW-1:0] head_r  [MAX_CPUS];
  logic [CW-1:0] count_r [MAX_CPUS];

  // Update head and size of the addressed queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CPUS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else if (we) begin
      head_r[q]  <= head_wr;
      count_r[q] <= count_wr;
    end
  end

  // Single read port at the same queue
  assign head_rd  = head_r[q];
  assign count_rd = count_r[q];

endmodule

FILE: design/mqtb_mem.sv
module mqtb_mem import mqtb_pkg::*; #(
  parameter int MAX_CPUS  = 8,
  parameter int PID_COUNT = 64,
  localparam int SlotDepth = MAX_CPUS * PID_COUNT,
  localparam int AW = (SlotDepth > 1) ? $clog2(SlotDepth) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mqtb_mem_ctl_t       ctl,
  input  logic [AW-1:0]       slot_addr,
  input  logic [TaskW-1:0]    slot_wdata,
  output logic [TaskW-1:0]    slot_rdata,
  input  logic [TaskW-1:0]    memb_addr,
  input  logic [MAX_CPUS-1:0] memb_wdata,
  output logic [MAX_CPUS-1:0] memb_rdata
);

  logic [TaskW-1:0]    slot_mem [SlotDepth];
  logic [TaskW-1:0]    slot_rdata_r;
  logic [MAX_CPUS-1:0] memb_mem [NumIds];
  logic [MAX_CPUS-1:0] memb_row_r;
  logic [NumIds-1:0]   memb_vld_r;
  logic                memb_hit_r;

  // Task slots of all run queues
  always_ff @(posedge clk) begin
    if (ctl.slot_we) begin
      slot_mem[slot_addr] <= slot_wdata;
    end
    slot_rdata_r <= slot_mem[slot_addr];
  end

  // Membership rows, one per task id
  always_ff @(posedge clk) begin
    if (ctl.memb_we) begin
      memb_mem[memb_addr] <= memb_wdata;
    end
    memb_row_r <= memb_mem[memb_addr];
    memb_hit_r <= memb_vld_r[memb_addr];
  end

  // Mark rows written since reset; others read as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      memb_vld_r <= '0;
    end else if (ctl.memb_we) begin
      memb_vld_r[memb_addr] <= 1'b1;
    end
  end

  assign slot_rdata = slot_rdata_r;
  assign memb_rdata = memb_hit_r ? memb_row_r : '0;

endmodule

FILE: design/multi_queue_task_balancer_core.sv
// Per-CPU run queues with balanced enqueue and work stealing. A command is
// taken when start is high and busy is low; its result is on the out ports,
// marked by out_valid, for exactly one cycle, the first cycle in which busy
// is low again, and must be taken then since the receiver cannot stall the
// block. Bad CPU, unused command and no-queue cases answer in the cycle after
// start with busy never high. The active_cpus queues (capped at MAX_CPUS)
// are in use. A balanced enqueue first scans for the least-filled queue
// with room; a dispatch pops the local head or, with that queue empty,
// scans for the largest other queue and moves its head here unless none is
// found or it is queue 0, else answers idle. The size scans go through one
// comparator a queue per cycle, and the slot and membership memories each
// have one registered port that every pop and push passes through.
module multi_queue_task_balancer_core import mqtb_pkg::*; #(
  parameter int MAX_CPUS  = 8,
  parameter int PID_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CmdW-1:0]    in_cmd,
  input  logic [TaskW-1:0]   in_task_id,
  input  logic [CpuW-1:0]    in_cpu_index,
  output logic               out_valid,
  output logic [StatusW-1:0] out_status,
  output logic [TaskW-1:0]   out_task_out,
  output logic [UsedW-1:0]   out_queue_used,
  output logic [FillW-1:0]   out_queue_fill,
  input  logic               cfg_we,
  input  logic [CfgW-1:0]    cfg_active_cpus
);

  localparam int QW        = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int PW        = $clog2(PID_COUNT);
  localparam int CW        = $clog2(PID_COUNT + 1);
  localparam int SlotDepth = MAX_CPUS * PID_COUNT;
  localparam int AW        = (SlotDepth > 1) ? $clog2(SlotDepth) : 1;
  localparam int NW        = ($clog2(MAX_CPUS + 1) > CfgW) ? $clog2(MAX_CPUS + 1) : CfgW;

  localparam logic [AW-1:0] PidA     = AW'(PID_COUNT);
  localparam logic [CW-1:0] FullCnt  = CW'(PID_COUNT);
  localparam logic [CW:0]   WrapCnt  = (CW+1)'(PID_COUNT);
  localparam logic [PW-1:0] LastHead = PW'(PID_COUNT - 1);
  localparam logic [NW-1:0] MaxN     = NW'(MAX_CPUS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_MIN,
    S_BAL_END,
    S_ENQ_CHK,
    S_ENQ_MEM,
    S_DISP,
    S_SCAN_MAX,
    S_STEAL_END,
    S_POP_ISS,
    S_POP_RD,
    S_POP_WR,
    S_PUSH
  } state_t;

  state_t            state_r, state_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [QW-1:0]     cpu_r, cpu_nxt;
  logic [TaskW-1:0]  task_r, task_nxt;
  logic [TaskW-1:0]  got_r, got_nxt;
  logic              steal_r, steal_nxt;
  logic              out_valid_r, out_valid_nxt;
  mqtb_status_t      out_status_r, out_status_nxt;
  logic [TaskW-1:0]  out_task_r, out_task_nxt;
  logic [UsedW-1:0]  out_used_r, out_used_nxt;
  logic [FillW-1:0]  out_fill_r, out_fill_nxt;
  logic [CfgW-1:0]   cfg_active_r;

  logic [NW-1:0]       act_ext;
  logic [NW-1:0]       live_n;
  logic                last_idx;
  logic [PW-1:0]       head_rd;
  logic [CW-1:0]       count_rd;
  logic [CW:0]         tail_sum;
  logic [PW-1:0]       tail_pos;
  logic [PW-1:0]       head_inc;
  logic [PW-1:0]       slot_pos;
  logic [AW-1:0]       slot_addr;
  logic [TaskW-1:0]    slot_rdata;
  logic [TaskW-1:0]    memb_addr;
  logic [MAX_CPUS-1:0] memb_wdata;
  logic [MAX_CPUS-1:0] memb_rdata;
  logic [MAX_CPUS-1:0] q_bit;
  logic [MAX_CPUS-1:0] cpu_bit;
  logic                dup;
  logic                qr_we;
  logic [PW-1:0]       qr_head_wr;
  logic [CW-1:0]       qr_count_wr;
  mqtb_mem_ctl_t       mem_ctl;
  mqtb_scan_ctl_t      scan_ctl;
  logic                scan_found;
  logic [QW-1:0]       scan_sel;
  mqtb_cmd_t           cmd;

  // Hold the queue count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_active_r <= CfgW'(1);
    end else if (cfg_we) begin
      cfg_active_r <= cfg_active_cpus;
    end
  end

  // Clamp the active queue count to the built queues
  assign act_ext  = NW'(cfg_active_r);
  assign live_n   = (act_ext > MaxN) ? MaxN : act_ext;
  assign last_idx = ((NW'(q_r) + NW'(1)) == live_n);
  assign cmd      = mqtb_cmd_t'(in_cmd);

  // Ring pointer arithmetic of the addressed queue
  assign tail_sum  = (CW+1)'(head_rd) + (CW+1)'(count_rd);
  assign tail_pos  = (tail_sum >= WrapCnt) ? PW'(tail_sum - WrapCnt) : PW'(tail_sum);
  assign head_inc  = (head_rd == LastHead) ? '0 : head_rd + PW'(1);
  assign slot_pos  = (state_r == S_POP_ISS) ? head_rd : tail_pos;
  assign slot_addr = AW'(q_r) * PidA + AW'(slot_pos);

  // Membership row access
  assign q_bit   = MAX_CPUS'(1) << q_r;
  assign cpu_bit = MAX_CPUS'(1) << cpu_r;
  assign dup     = memb_rdata[q_r];

  always_comb begin
    case (state_r)
      S_POP_RD: memb_addr = slot_rdata;
      S_POP_WR: memb_addr = got_r;
      default:  memb_addr = task_r;
    endcase
    if (state_r == S_POP_WR) begin
      memb_wdata = (memb_rdata & ~q_bit) | (steal_r ? cpu_bit : '0);
    end else begin
      memb_wdata = memb_rdata | q_bit;
    end
  end

  // Memory and queue register write controls
  always_comb begin
    mem_ctl.slot_we = ((state_r == S_ENQ_MEM) && !dup) || (state_r == S_PUSH);
    mem_ctl.memb_we = ((state_r == S_ENQ_MEM) && !dup) || (state_r == S_POP_WR);
    qr_we           = mem_ctl.slot_we || (state_r == S_POP_WR);
    if (state_r == S_POP_WR) begin
      qr_head_wr  = head_inc;
      qr_count_wr = count_rd - CW'(1);
    end else begin
      qr_head_wr  = head_rd;
      qr_count_wr = count_rd + CW'(1);
    end
  end

  // Shared comparator controls
  always_comb begin
    scan_ctl.clear    = ((state_r == S_IDLE) && start && (cmd == CMD_BAL)) ||
                        ((state_r == S_DISP) && (count_rd == '0));
    scan_ctl.step     = (state_r == S_SCAN_MIN) || (state_r == S_SCAN_MAX);
    scan_ctl.find_max = (state_r == S_SCAN_MAX);
    scan_ctl.skip     = (q_r == cpu_r);
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    q_nxt          = q_r;
    cpu_nxt        = cpu_r;
    task_nxt       = task_r;
    got_nxt        = got_r;
    steal_nxt      = steal_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_task_nxt   = out_task_r;
    out_used_nxt   = out_used_r;
    out_fill_nxt   = out_fill_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          task_nxt  = in_task_id;
          cpu_nxt   = QW'(in_cpu_index);
          steal_nxt = 1'b0;
          out_task_nxt = '0;
          out_used_nxt = '0;
          out_fill_nxt = '0;
          unique case (cmd)
            CMD_BAL: begin
              if (live_n == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NOTGT;
              end else begin
                q_nxt     = '0;
                state_nxt = S_SCAN_MIN;
              end
            end
            CMD_NONE: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NOTGT;
            end
            CMD_LOCAL, CMD_DISP: begin
              if (NW'(in_cpu_index) >= live_n) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_BADCPU;
              end else begin
                q_nxt     = QW'(in_cpu_index);
                state_nxt = (cmd == CMD_LOCAL) ? S_ENQ_CHK : S_DISP;
              end
            end
          endcase
        end
      end

      // Find the first least-filled queue with room
      S_SCAN_MIN: begin
        if (last_idx) begin
          state_nxt = S_BAL_END;
        end else begin
          q_nxt = q_r + QW'(1);
        end
      end

      S_BAL_END: begin
        if (!scan_found) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOTGT;
          out_task_nxt   = '0;
          out_used_nxt   = '0;
          out_fill_nxt   = '0;
          state_nxt      = S_IDLE;
        end else begin
          q_nxt     = scan_sel;
          state_nxt = S_ENQ_CHK;
        end
      end

      // Reject a full queue, else fetch the membership row
      S_ENQ_CHK: begin
        if (count_rd == FullCnt) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOTGT;
          out_task_nxt   = '0;
          out_used_nxt   = UsedW'(q_r);
          out_fill_nxt   = FillW'(count_rd);
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_ENQ_MEM;
        end
      end

      // Append unless the task is already queued here
      S_ENQ_MEM: begin
        out_valid_nxt = 1'b1;
        out_used_nxt  = UsedW'(q_r);
        state_nxt     = S_IDLE;
        if (dup) begin
          out_status_nxt = ST_DUP;
          out_task_nxt   = '0;
          out_fill_nxt   = FillW'(count_rd);
        end else begin
          out_status_nxt = ST_ENQ;
          out_task_nxt   = task_r;
          out_fill_nxt   = FillW'(count_rd + CW'(1));
        end
      end

      // Pop locally, or look for a queue to rob
      S_DISP: begin
        if (count_rd != '0) begin
          state_nxt = S_POP_ISS;
        end else begin
          q_nxt     = '0;
          state_nxt = S_SCAN_MAX;
        end
      end

      // Find the first largest other queue
      S_SCAN_MAX: begin
        if (last_idx) begin
          state_nxt = S_STEAL_END;
        end else begin
          q_nxt = q_r + QW'(1);
        end
      end

      S_STEAL_END: begin
        if (!scan_found || (scan_sel == '0)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_IDLE;
          out_task_nxt   = '0;
          out_used_nxt   = UsedW'(cpu_r);
          out_fill_nxt   = '0;
          state_nxt      = S_IDLE;
        end else begin
          q_nxt     = scan_sel;
          steal_nxt = 1'b1;
          state_nxt = S_POP_ISS;
        end
      end

      // Read the head slot
      S_POP_ISS: begin
        state_nxt = S_POP_RD;
      end

      S_POP_RD: begin
        got_nxt   = slot_rdata;
        state_nxt = S_POP_WR;
      end

      // Retire the head; a steal goes on to the local push
      S_POP_WR: begin
        if (steal_r) begin
          q_nxt     = cpu_r;
          state_nxt = S_PUSH;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DISP;
          out_task_nxt   = got_r;
          out_used_nxt   = UsedW'(q_r);
          out_fill_nxt   = FillW'(count_rd - CW'(1));
          state_nxt      = S_IDLE;
        end
      end

      S_PUSH: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_STOLEN;
        out_task_nxt   = got_r;
        out_used_nxt   = UsedW'(scan_sel);
        out_fill_nxt   = FillW'(count_rd + CW'(1));
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      steal_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      steal_r     <= steal_nxt;
    end
    q_r          <= q_nxt;
    cpu_r        <= cpu_nxt;
    task_r       <= task_nxt;
    got_r        <= got_nxt;
    out_status_r <= out_status_nxt;
    out_task_r   <= out_task_nxt;
    out_used_r   <= out_used_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  mqtb_qregs #(
    .MAX_CPUS  (MAX_CPUS),
    .PID_COUNT (PID_COUNT)
  ) u_qregs (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (qr_we),
    .q        (q_r),
    .head_wr  (qr_head_wr),
    .count_wr (qr_count_wr),
    .head_rd  (head_rd),
    .count_rd (count_rd)
  );

  mqtb_scan #(
    .MAX_CPUS  (MAX_CPUS),
    .PID_COUNT (PID_COUNT)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .idx   (q_r),
    .size  (count_rd),
    .found (scan_found),
    .sel   (scan_sel)
  );

  mqtb_mem #(
    .MAX_CPUS  (MAX_CPUS),
    .PID_COUNT (PID_COUNT)
  ) u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mem_ctl),
    .slot_addr  (slot_addr),
    .slot_wdata (got_r & {TaskW{state_r == S_PUSH}} | task_r & {TaskW{state_r != S_PUSH}}),
    .slot_rdata (slot_rdata),
    .memb_addr  (memb_addr),
    .memb_wdata (memb_wdata),
    .memb_rdata (memb_rdata)
  );

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_task_out   = out_task_r;
  assign out_queue_used = out_used_r;
  assign out_queue_fill = out_fill_r;

endmodule
